### rtl/esmf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// esmf_pkg
// Shared constants and control types of the encoder speed median filter.
// ============================================================================
package esmf_pkg;

    localparam int POS_W     = 31;
    localparam int DIFF_W    = 32;
    localparam int SPEED_W   = 16;
    localparam int RES_W     = 5;
    localparam int SCALE_W   = 40;
    localparam int CFG_IDX_W = 1;
    localparam int STARTUP_W = 8;

    localparam int FILTER_DEPTH_DEFAULT = 8;

    localparam logic [STARTUP_W-1:0] STARTUP_SAMPLES = 8'd10;
    localparam logic [RES_W-1:0]     RES_BITS_RESET  = 5'd17;

    localparam logic [CFG_IDX_W-1:0] CFG_RESOLUTION_BITS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_SCALE       = 1'b1;

    typedef struct packed {
        logic load;
        logic fold;
        logic absval;
        logic mul_lo;
        logic mul_hi;
        logic sat;
        logic sort_load;
        logic sort_step;
        logic sort_odd;
        logic pick_hi;
        logic pick_lo;
        logic out_load;
    } esmf_cmd_t;

    typedef struct packed {
        logic in_startup;
    } esmf_stat_t;

endpackage

### rtl/esmf_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// esmf_ctrl
// Sequencer that steps one encoder sample through the speed datapath.
// ============================================================================
module esmf_ctrl #(
    parameter int FILTER_DEPTH = esmf_pkg::FILTER_DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  esmf_pkg::esmf_stat_t stat,
    output esmf_pkg::esmf_cmd_t  cmd
);
    import esmf_pkg::*;

    localparam int CNT_W = $clog2(FILTER_DEPTH + 1);
    localparam logic [CNT_W-1:0] LAST_PASS = CNT_W'(FILTER_DEPTH - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FOLD,
        ST_ABS,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_SAT,
        ST_SORT_LOAD,
        ST_SORT,
        ST_PICK_HI,
        ST_PICK_LO,
        ST_OUTPUT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] pass_reg;
    logic             out_valid_reg;
    logic             out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:      cmd.load      = s_tvalid;
            ST_FOLD:      cmd.fold      = 1'b1;
            ST_ABS:       cmd.absval    = 1'b1;
            ST_MUL_LO:    cmd.mul_lo    = 1'b1;
            ST_MUL_HI:    cmd.mul_hi    = 1'b1;
            ST_SAT:       cmd.sat       = 1'b1;
            ST_SORT_LOAD: cmd.sort_load = 1'b1;
            ST_SORT: begin
                cmd.sort_step = 1'b1;
                cmd.sort_odd  = pass_reg[0];
            end
            ST_PICK_HI:   cmd.pick_hi   = 1'b1;
            ST_PICK_LO:   cmd.pick_lo   = 1'b1;
            ST_OUTPUT:    cmd.out_load  = out_free;
            default:      cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        state_reg <= ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    state_reg <= stat.in_startup ? ST_OUTPUT : ST_ABS;
                end
                ST_ABS:       state_reg <= ST_MUL_LO;
                ST_MUL_LO:    state_reg <= ST_MUL_HI;
                ST_MUL_HI:    state_reg <= ST_SAT;
                ST_SAT:       state_reg <= ST_SORT_LOAD;
                ST_SORT_LOAD: begin
                    pass_reg  <= '0;
                    state_reg <= ST_SORT;
                end
                ST_SORT: begin
                    pass_reg <= pass_reg + 1'b1;
                    if (pass_reg == LAST_PASS) begin
                        state_reg <= ST_PICK_HI;
                    end
                end
                ST_PICK_HI:   state_reg <= ST_PICK_LO;
                ST_PICK_LO:   state_reg <= ST_OUTPUT;
                ST_OUTPUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:      state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

### rtl/esmf_datapath.sv
`timescale 1ns / 1ps
// ============================================================================
// esmf_datapath
// Position difference, rpm scaling, speed ring and median sort network.
// ============================================================================
module esmf_datapath #(
    parameter int FILTER_DEPTH = esmf_pkg::FILTER_DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [esmf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [esmf_pkg::SCALE_W-1:0]        cfg_data,
    input  logic [esmf_pkg::POS_W-1:0]          position,
    input  esmf_pkg::esmf_cmd_t                 cmd,
    output esmf_pkg::esmf_stat_t                stat,
    output logic signed [esmf_pkg::DIFF_W-1:0]  out_pos_diff,
    output logic signed [esmf_pkg::SPEED_W-1:0] out_raw_speed,
    output logic signed [esmf_pkg::SPEED_W-1:0] out_filtered_speed,
    output logic                                out_speed_valid
);
    import esmf_pkg::*;

    localparam int IDX_W = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int CNT_W = $clog2(FILTER_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FILTER_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(FILTER_DEPTH);

    logic [RES_W-1:0]         res_bits_reg;
    logic [SCALE_W-1:0]       rpm_scale_reg;
    logic [POS_W-1:0]         last_pos_reg;
    logic [STARTUP_W-1:0]     startup_cnt_reg;
    logic signed [DIFF_W:0]   diff_reg;
    logic signed [DIFF_W-1:0] pos_diff_reg;
    logic                     valid_flag_reg;
    logic [DIFF_W-1:0]        mag_reg;
    logic                     neg_reg;
    logic [63:0]              prod_lo_reg;
    logic [SCALE_W-1:0]       prod_hi_reg;
    logic signed [SPEED_W-1:0] held_raw_reg;
    logic signed [SPEED_W-1:0] held_filt_reg;
    logic signed [SPEED_W-1:0] ring_reg [FILTER_DEPTH];
    logic [IDX_W-1:0]         wr_idx_reg;
    logic                     filled_reg;
    logic signed [SPEED_W-1:0] sort_val_reg [FILTER_DEPTH];
    logic                     sort_vld_reg [FILTER_DEPTH];
    logic signed [SPEED_W-1:0] sort_val_next [FILTER_DEPTH];
    logic                     sort_vld_next [FILTER_DEPTH];
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_now;
    logic signed [SPEED_W-1:0] med_hi_reg;

    logic signed [DIFF_W-1:0] pos_diff_reg_q;
    logic signed [DIFF_W-1:0] out_diff_reg;
    logic signed [SPEED_W-1:0] out_raw_reg;
    logic signed [SPEED_W-1:0] out_filt_reg;
    logic                     out_flag_reg;

    logic [RES_W-1:0]         bits_eff;
    logic [DIFF_W:0]          turn;
    logic [DIFF_W:0]          half;
    logic signed [DIFF_W:0]   folded;
    logic [31:0]              mul_b;
    logic [63:0]              prod;
    logic [56:0]              q;
    logic signed [SPEED_W-1:0] sat_speed;
    logic [IDX_W-1:0]         mid_idx;
    logic [IDX_W-1:0]         lo_idx;
    logic [IDX_W-1:0]         rd_idx;
    logic signed [SPEED_W-1:0] rd_val;
    logic signed [SPEED_W:0]  pair_sum;
    logic signed [SPEED_W:0]  pair_adj;
    logic signed [SPEED_W-1:0] median;

    assign stat.in_startup = (startup_cnt_reg < STARTUP_SAMPLES);
    assign pos_diff_reg_q  = pos_diff_reg;

    assign bits_eff = (res_bits_reg == '0) ? RES_W'(1) : res_bits_reg;
    assign turn     = (DIFF_W + 1)'(1) << bits_eff;
    assign half     = turn >> 1;

    always_comb begin
        if (diff_reg > $signed(half)) begin
            folded = diff_reg - $signed(turn);
        end else if (diff_reg < -$signed(half)) begin
            folded = diff_reg + $signed(turn);
        end else begin
            folded = diff_reg;
        end
    end

    assign mul_b = cmd.mul_hi ? {24'd0, rpm_scale_reg[SCALE_W-1:32]} : rpm_scale_reg[31:0];
    assign prod  = 64'(mag_reg) * 64'(mul_b);

    assign q = 57'(prod_lo_reg[63:16]) + {1'b0, prod_hi_reg, 16'd0};

    always_comb begin
        if (neg_reg) begin
            sat_speed = (q >= 57'd32768) ? -16'sd32768 : $signed(-q[SPEED_W-1:0]);
        end else begin
            sat_speed = (q > 57'd32767) ? 16'sd32767 : $signed(q[SPEED_W-1:0]);
        end
    end

    assign count_now = filled_reg ? FULL_CNT : CNT_W'(wr_idx_reg);

    always_comb begin
        for (int i = 0; i < FILTER_DEPTH; i++) begin
            sort_val_next[i] = sort_val_reg[i];
            sort_vld_next[i] = sort_vld_reg[i];
        end
        for (int i = 0; i < FILTER_DEPTH - 1; i++) begin
            if (i[0] == cmd.sort_odd) begin
                if ((!sort_vld_reg[i] && sort_vld_reg[i+1]) ||
                    (sort_vld_reg[i] && sort_vld_reg[i+1] &&
                     sort_val_reg[i] > sort_val_reg[i+1])) begin
                    sort_val_next[i]   = sort_val_reg[i+1];
                    sort_vld_next[i]   = sort_vld_reg[i+1];
                    sort_val_next[i+1] = sort_val_reg[i];
                    sort_vld_next[i+1] = sort_vld_reg[i];
                end
            end
        end
    end

    assign mid_idx  = IDX_W'(count_reg >> 1);
    assign lo_idx   = count_reg[0] ? mid_idx : mid_idx - 1'b1;
    assign rd_idx   = cmd.pick_lo ? lo_idx : mid_idx;
    assign rd_val   = sort_val_reg[rd_idx];
    assign pair_sum = {rd_val[SPEED_W-1], rd_val} + {med_hi_reg[SPEED_W-1], med_hi_reg};
    assign pair_adj = pair_sum + (SPEED_W + 1)'(pair_sum[SPEED_W]);
    assign median   = count_reg[0] ? med_hi_reg : pair_adj[SPEED_W:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_bits_reg    <= RES_BITS_RESET;
            rpm_scale_reg   <= '0;
            last_pos_reg    <= '0;
            startup_cnt_reg <= '0;
            wr_idx_reg      <= '0;
            filled_reg      <= 1'b0;
            held_raw_reg    <= '0;
            held_filt_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_index == CFG_RESOLUTION_BITS) begin
                res_bits_reg <= cfg_data[RES_W-1:0];
            end
            if (cfg_valid && cfg_index == CFG_RPM_SCALE) begin
                rpm_scale_reg <= cfg_data;
            end
            if (cmd.load) begin
                last_pos_reg <= position;
            end
            if (cmd.fold && stat.in_startup) begin
                startup_cnt_reg <= startup_cnt_reg + 1'b1;
            end
            if (cmd.sat) begin
                held_raw_reg <= sat_speed;
                if (wr_idx_reg == LAST_IDX) begin
                    wr_idx_reg <= '0;
                    filled_reg <= 1'b1;
                end else begin
                    wr_idx_reg <= wr_idx_reg + 1'b1;
                end
            end
            if (cmd.pick_lo) begin
                held_filt_reg <= median;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            diff_reg <= $signed({2'b00, position}) - $signed({2'b00, last_pos_reg});
        end
        if (cmd.fold) begin
            pos_diff_reg   <= folded[DIFF_W-1:0];
            valid_flag_reg <= !stat.in_startup;
        end
        if (cmd.absval) begin
            mag_reg <= pos_diff_reg[DIFF_W-1] ? -pos_diff_reg : pos_diff_reg;
            neg_reg <= pos_diff_reg[DIFF_W-1];
        end
        if (cmd.mul_lo) begin
            prod_lo_reg <= prod;
        end
        if (cmd.mul_hi) begin
            prod_hi_reg <= prod[SCALE_W-1:0];
        end
        if (cmd.sat) begin
            ring_reg[wr_idx_reg] <= sat_speed;
        end
        if (cmd.sort_load) begin
            count_reg <= count_now;
            for (int i = 0; i < FILTER_DEPTH; i++) begin
                sort_val_reg[i] <= ring_reg[i];
                sort_vld_reg[i] <= (CNT_W'(i) < count_now);
            end
        end else if (cmd.sort_step) begin
            for (int i = 0; i < FILTER_DEPTH; i++) begin
                sort_val_reg[i] <= sort_val_next[i];
                sort_vld_reg[i] <= sort_vld_next[i];
            end
        end
        if (cmd.pick_hi) begin
            med_hi_reg <= rd_val;
        end
        if (cmd.out_load) begin
            out_diff_reg <= pos_diff_reg_q;
            out_raw_reg  <= held_raw_reg;
            out_filt_reg <= held_filt_reg;
            out_flag_reg <= valid_flag_reg;
        end
    end

    assign out_pos_diff       = out_diff_reg;
    assign out_raw_speed      = out_raw_reg;
    assign out_filtered_speed = out_filt_reg;
    assign out_speed_valid    = out_flag_reg;

endmodule

### rtl/encoder_speed_median_filter_core.sv
`timescale 1ns / 1ps
// ============================================================================
// encoder_speed_median_filter_core
// Encoder speed in rpm from absolute positions, with a median filter.
// ============================================================================
// Each accepted position produces exactly one result transfer. A sample in the
// startup window goes from acceptance through the fold step straight to the
// output register; after that a sample also takes the two passes through the
// shared 32x32 multiplier and the FILTER_DEPTH passes of the odd-even
// transposition sort over the speed ring. A new position is accepted once the
// previous result has been placed in the output register, even if that result
// has not yet been taken. Configuration writes are always accepted and must be
// issued only while the block is idle.
module encoder_speed_median_filter_core #(
    parameter int FILTER_DEPTH = esmf_pkg::FILTER_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [esmf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [esmf_pkg::SCALE_W-1:0]   cfg_data,
    // Input stream: tdata[30:0] position, tdata[31] zero.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,
    // Output stream: tdata[31:0] pos_diff, [47:32] raw_speed, [63:48] filtered_speed.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_tdata,
    // Output stream: tuser[0] speed_valid.
    output logic [0:0]                     m_tuser
);
    import esmf_pkg::*;

    esmf_cmd_t                 cmd;
    esmf_stat_t                stat;
    logic signed [DIFF_W-1:0]  pos_diff;
    logic signed [SPEED_W-1:0] raw_speed;
    logic signed [SPEED_W-1:0] filtered_speed;
    logic                      speed_valid;

    assign cfg_ready = 1'b1;

    esmf_ctrl #(
        .FILTER_DEPTH(FILTER_DEPTH)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    esmf_datapath #(
        .FILTER_DEPTH(FILTER_DEPTH)
    ) u_datapath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .position           (s_tdata[POS_W-1:0]),
        .cmd                (cmd),
        .stat               (stat),
        .out_pos_diff       (pos_diff),
        .out_raw_speed      (raw_speed),
        .out_filtered_speed (filtered_speed),
        .out_speed_valid    (speed_valid)
    );

    assign m_tdata = {filtered_speed, raw_speed, pos_diff};
    assign m_tuser = speed_valid;

    // A sample is still in work in the cycle after its transfer, so input is not ready.
    property p_busy_after_accept;
        @(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready;
    endproperty
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("Input accepted again right after a transfer.");

    // Speeds stay at their reset value until startup is over.
    property p_startup_speeds_zero;
        @(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata[63:32] == 32'd0);
    endproperty
    a_startup_speeds_zero: assert property (p_startup_speeds_zero)
        else $error("Speed changed during the startup window.");

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking regression for the encoder speed median filter core.
// ============================================================================
// A short table of directed positions and register writes runs first. It
// covers the startup window, half-turn folding at and around its edges,
// positions beyond one turn, a resolution of zero, both saturation limits,
// truncation of negative speeds and the median over a wrapped ring. Random
// phases follow, each with new register values and mostly smooth encoder
// motion mixed with jumps and arbitrary positions. Every result transfer is
// compared field by field with an in-order prediction. Both stream sides
// idle at random, and the receiver holds off once long enough to stall input.
// ============================================================================
module testbench;
    import esmf_pkg::*;

    localparam int          RING_DEPTH   = FILTER_DEPTH_DEFAULT;
    localparam int          HOLD_CYCLES  = 80;
    localparam int          NUM_PHASES   = 10;
    localparam int          PHASE_ITEMS  = 123;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          PRINT_LIMIT  = 40;

    typedef struct packed {
        logic signed [DIFF_W-1:0]  pos_diff;
        logic signed [SPEED_W-1:0] raw_speed;
        logic signed [SPEED_W-1:0] filt_speed;
        logic                      speed_valid;
    } speed_result_t;

    typedef enum logic [0:0] {
        ROW_POS,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [SCALE_W-1:0]     value;
        logic                   typed;
        speed_result_t          want;
    } stim_row_t;

    localparam speed_result_t NO_WANT = '0;

    localparam stim_row_t DIR_ROWS [29] = '{
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd0, 1'b1, '{32'sd0, 16'sd0, 16'sd0, 1'b0}},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd1000, 1'b1, '{32'sd1000, 16'sd0, 16'sd0, 1'b0}},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd2147483647, 1'b1,
          '{32'sd2147351575, 16'sd0, 16'sd0, 1'b0}},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd0, 1'b1,
          '{-32'sd2147352575, 16'sd0, 16'sd0, 1'b0}},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd65536, 1'b1, '{32'sd65536, 16'sd0, 16'sd0, 1'b0}},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd0, 1'b1, '{-32'sd65536, 16'sd0, 16'sd0, 1'b0}},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd65537, 1'b1, '{-32'sd65535, 16'sd0, 16'sd0, 1'b0}},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd0, 1'b1, '{32'sd65535, 16'sd0, 16'sd0, 1'b0}},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd131071, 1'b1, '{-32'sd1, 16'sd0, 16'sd0, 1'b0}},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd5, 1'b1, '{32'sd6, 16'sd0, 16'sd0, 1'b0}},
        '{ROW_CFG, CFG_RPM_SCALE, 40'hFF_FFFF_FFFF, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_RESOLUTION_BITS, 40'd0, 1'b0, NO_WANT},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd5, 1'b1, '{32'sd0, 16'sd0, 16'sd0, 1'b1}},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd6, 1'b1,
          '{32'sd1, 16'sd32767, 16'sd16383, 1'b1}},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd4, 1'b1, '{32'sd0, 16'sd0, 16'sd0, 1'b1}},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd3, 1'b1, '{-32'sd1, 16'h8000, 16'sd0, 1'b1}},
        '{ROW_CFG, CFG_RESOLUTION_BITS, 40'd31, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_RPM_SCALE, 40'h1_0000, 1'b0, NO_WANT},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd2147483647, 1'b0, NO_WANT},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd1073741824, 1'b0, NO_WANT},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd0, 1'b0, NO_WANT},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd1073741824, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_RESOLUTION_BITS, 40'd17, 1'b0, NO_WANT},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd1073774592, 1'b0, NO_WANT},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd1073741824, 1'b0, NO_WANT},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd1073774591, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_RPM_SCALE, 40'h8000, 1'b0, NO_WANT},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd1073774594, 1'b0, NO_WANT},
        '{ROW_POS, CFG_RESOLUTION_BITS, 40'd1073774591, 1'b0, NO_WANT}
    };

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SCALE_W-1:0]   cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;   // [30:0] position, [31] zero
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [63:0]          m_tdata;          // [31:0] pos_diff, [47:32] raw, [63:48] filtered
    logic [0:0]           m_tuser;          // [0] speed_valid

    // Predictor copy of the block's registers and state.
    logic [RES_W-1:0]          res_bits    = RES_BITS_RESET;
    logic [SCALE_W-1:0]        scale_q     = '0;
    logic [POS_W-1:0]          last_pos    = '0;
    logic [STARTUP_W-1:0]      startup_cnt = '0;
    logic signed [SPEED_W-1:0] ring [RING_DEPTH];
    int                        ring_wr     = 0;
    bit                        ring_full   = 1'b0;
    logic signed [SPEED_W-1:0] held_raw    = '0;
    logic signed [SPEED_W-1:0] held_filt   = '0;

    speed_result_t pending_speeds[$];
    int            mismatches   = 0;
    int unsigned   cycle_count  = 0;
    bit            calm         = 1'b0;
    bit            hold_request = 1'b0;

    encoder_speed_median_filter_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("encoder_speed_median_filter_core regression: fail");
        $finish;
    end

    function automatic speed_result_t predict_speed(input logic [POS_W-1:0] pos);
        speed_result_t      r;
        logic signed [63:0] diff;
        logic signed [63:0] turn;
        logic signed [63:0] half;
        logic [63:0]        mag;
        logic [103:0]       prod;
        logic [87:0]        q;
        int                 sorted [RING_DEPTH];
        int                 count;
        int                 j;
        int                 v;
        int                 mid;
        int unsigned        bits;
        bits = (res_bits == 0) ? 1 : res_bits;
        turn = 64'sd1 <<< bits;
        half = turn >>> 1;
        diff = $signed({33'd0, pos}) - $signed({33'd0, last_pos});
        last_pos = pos;
        if (diff > half) begin
            diff = diff - turn;
        end else if (diff < -half) begin
            diff = diff + turn;
        end
        r.speed_valid = 1'b0;
        if (startup_cnt < STARTUP_SAMPLES) begin
            startup_cnt++;
        end else begin
            mag  = (diff < 0) ? -diff : diff;
            prod = mag * scale_q;
            q    = prod[103:16];
            if (diff < 0) begin
                held_raw = (q >= 32768) ? 16'h8000 : -$signed({1'b0, q[14:0]});
            end else begin
                held_raw = (q > 32767) ? 16'h7FFF : $signed({1'b0, q[14:0]});
            end
            ring[ring_wr] = held_raw;
            if (ring_wr == RING_DEPTH - 1) begin
                ring_wr   = 0;
                ring_full = 1'b1;
            end else begin
                ring_wr++;
            end
            count = ring_full ? RING_DEPTH : ring_wr;
            for (int i = 0; i < count; i++) begin
                v = ring[i];
                j = i;
                while (j > 0 && sorted[j - 1] > v) begin
                    sorted[j] = sorted[j - 1];
                    j--;
                end
                sorted[j] = v;
            end
            mid = count / 2;
            if (count % 2 == 0) begin
                held_filt = 16'((sorted[mid - 1] + sorted[mid]) / 2);
            end else begin
                held_filt = 16'(sorted[mid]);
            end
            r.speed_valid = 1'b1;
        end
        r.pos_diff   = diff[31:0];
        r.raw_speed  = held_raw;
        r.filt_speed = held_filt;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint got, input longint want);
        if (mismatches < PRINT_LIMIT) begin
            $display("mismatch in %s: got %0d, expected %0d (cycle %0d)",
                     what, got, want, cycle_count);
        end
        mismatches++;
    endtask

    // The stream valid is lowered here rather than after each transfer, so that
    // back-to-back items keep it high without a second assignment in one step.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_speeds.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCALE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_RESOLUTION_BITS) begin
            res_bits = data[RES_W-1:0];
        end else begin
            scale_q = data;
        end
    endtask

    task automatic send_position(input logic [POS_W-1:0] pos, input logic typed,
                                 input speed_result_t typed_want);
        speed_result_t predicted;
        cfg_valid <= 1'b0;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pos};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_speed(pos);
        pending_speeds.push_back(typed ? typed_want : predicted);
    endtask

    initial begin
        while (!aresetn) begin
            @(posedge aclk);
        end
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_request = 1'b0;
                m_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        speed_result_t got;
        speed_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.pos_diff    = m_tdata[31:0];
            got.raw_speed   = m_tdata[47:32];
            got.filt_speed  = m_tdata[63:48];
            got.speed_valid = m_tuser[0];
            if (pending_speeds.size() == 0) begin
                flag_mismatch("unexpected transfer, pos_diff", got.pos_diff, 0);
            end else begin
                want = pending_speeds.pop_front();
                if (got.pos_diff !== want.pos_diff)
                    flag_mismatch("pos_diff", got.pos_diff, want.pos_diff);
                if (got.raw_speed !== want.raw_speed)
                    flag_mismatch("raw_speed", got.raw_speed, want.raw_speed);
                if (got.filt_speed !== want.filt_speed)
                    flag_mismatch("filtered_speed", got.filt_speed, want.filt_speed);
                if (got.speed_valid !== want.speed_valid)
                    flag_mismatch("speed_valid", got.speed_valid, want.speed_valid);
            end
        end
    end

    initial begin
        logic [RES_W-1:0]   res;
        logic [SCALE_W-1:0] scale;
        logic [POS_W-1:0]   gen_pos;
        logic [POS_W-1:0]   turn_mask;
        int                 step;
        int                 delta;
        gen_pos = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (DIR_ROWS[n]) begin
            if (DIR_ROWS[n].kind == ROW_CFG) begin
                wait_drained();
                write_reg(DIR_ROWS[n].reg_idx, DIR_ROWS[n].value);
            end else begin
                send_position(DIR_ROWS[n].value[POS_W-1:0], DIR_ROWS[n].typed,
                              DIR_ROWS[n].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            if (ph == 0) begin
                res   = 5'd31;
                scale = '1;
            end else if (ph == 1) begin
                res   = 5'd1;
                scale = '0;
            end else begin
                res = RES_W'($urandom_range(0, 31));
                case ($urandom_range(0, 3))
                    0:       scale = SCALE_W'({$urandom, $urandom});
                    1:       scale = SCALE_W'($urandom_range(0, 1 << 20));
                    default: scale = SCALE_W'($urandom_range(1 << 12, 1 << 18));
                endcase
            end
            write_reg(CFG_RESOLUTION_BITS, SCALE_W'(res));
            write_reg(CFG_RPM_SCALE, scale);
            turn_mask = (res == 0) ? POS_W'(1) : POS_W'((64'd1 << res) - 1);
            step      = $urandom_range(0, 3000);
            calm      = (ph == NUM_PHASES - 1);
            if (ph == 3) begin
                hold_request = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 5 && k == PHASE_ITEMS / 2) begin
                    wait_drained();
                end
                case ($urandom_range(0, 9))
                    0:       gen_pos = POS_W'($urandom);
                    1:       gen_pos = POS_W'($urandom) & turn_mask;
                    2:       gen_pos = POS_W'(gen_pos + (turn_mask >> 1) + $urandom_range(0, 2))
                                       & turn_mask;
                    default: begin
                        delta   = $urandom_range(0, 2 * step) - step;
                        gen_pos = POS_W'(gen_pos + delta) & turn_mask;
                    end
                endcase
                send_position(gen_pos, 1'b0, NO_WANT);
            end
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (mismatches == 0) begin
            $display("encoder_speed_median_filter_core regression: pass");
        end else begin
            $display("encoder_speed_median_filter_core regression: fail");
        end
        $finish;
    end

endmodule
